// ----- sv/sit_pkg.sv -----
// Package: shared types, constants and codes for the sorted interval table.
`default_nettype none
package sit_pkg;
   localparam int CAPACITY     = 64;
   localparam int ADDR_BITS    = 48;
   localparam int PAYLOAD_BITS = 32;
   localparam int IDX_BITS     = $clog2(CAPACITY);
   localparam int CNT_BITS     = $clog2(CAPACITY + 1);
   localparam int ENTRY_BITS   = 2 * ADDR_BITS + PAYLOAD_BITS;

   localparam logic [2:0] OP_INSERT     = 3'd0;
   localparam logic [2:0] OP_DEL_POINT  = 3'd1;
   localparam logic [2:0] OP_DEL_RANGE  = 3'd2;
   localparam logic [2:0] OP_FIND       = 3'd3;
   localparam logic [2:0] OP_READ       = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_OVERLAP   = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_BAD_INDEX = 3'd4;

   typedef struct packed {
      logic [2:0]              operation;
      logic [ADDR_BITS-1:0]    range_begin;
      logic [ADDR_BITS-1:0]    range_end;
      logic [PAYLOAD_BITS-1:0] payload;
      logic [ADDR_BITS-1:0]    point;
      logic [5:0]              entry_index;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic [47:0]             found_begin;
      logic [47:0]             found_end;
      logic [31:0]             found_payload;
      logic [6:0]              removed_count;
      logic [6:0]              entry_count;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]    rbegin;
      logic [ADDR_BITS-1:0]    rend;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request, zero cursors
      logic rd_issue;   // read memory at rd_addr
      logic scan_step;  // advance scan cursor
      logic mark_end;   // freeze scan cursor as end of delete span
      logic set_cursor; // copy scan cursor (or occupancy when shift_up) to write cursor
      logic shift_up;   // move direction toward high index (insert)
      logic shift_dn;   // move direction toward low index (delete)
      logic mv_wr;      // write moved entry at cursor, step cursor
      logic wr_new;     // write new entry at cursor
      logic cnt_inc;
      logic cnt_dec;
      logic capture;    // latch found data from read port
      logic [2:0] status;
      logic rsp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] operation;
      logic scan_done;     // scan cursor reached occupancy
      logic end_le_key;    // stored end <= key
      logic begin_le_key;  // stored begin <= point
      logic overlap;       // insert overlap with scanned entry
      logic begin_lt_end;  // stored begin < range end
      logic full;
      logic idx_ok;
      logic move_done;     // shift sequence finished
   } sts_type;
endpackage
`default_nettype wire

// ----- sv/sit_datapath.sv -----
// Datapath: entry memory, cursors, occupancy counter and result register.
`default_nettype none
module sit_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sit_pkg::req_type  req_data,
   input  wire sit_pkg::cmd_type  cmd,
   output sit_pkg::sts_type       sts,
   output sit_pkg::rsp_type       rsp_data
);
   localparam int IB = sit_pkg::IDX_BITS;
   localparam int CB = sit_pkg::CNT_BITS;

   sit_pkg::entry_type mem [sit_pkg::CAPACITY];
   sit_pkg::entry_type rd_ff;
   sit_pkg::req_type   req_ff;
   sit_pkg::rsp_type   rsp_ff;
   logic [CB-1:0] occ_ff, occ_in;
   logic [CB-1:0] scan_ff, scan_in;   // scan position; next memory read address
   logic [CB-1:0] end_ff, end_in;     // end of delete span; move source when deleting
   logic [CB-1:0] wr_ff, wr_in;       // shift cursor
   logic [47:0]   fb_ff, fe_ff;
   logic [31:0]   fp_ff;
   logic [CB-1:0] rd_addr;
   logic [CB-1:0] n_rm;
   logic [sit_pkg::ADDR_BITS-1:0] key;

   assign key = (req_ff.operation == sit_pkg::OP_INSERT ||
                 req_ff.operation == sit_pkg::OP_DEL_RANGE) ? req_ff.range_begin : req_ff.point;
   assign n_rm = end_ff - wr_ff;

   always_comb begin
      rd_addr = scan_ff;
      if (cmd.shift_up) rd_addr = wr_ff - CB'(1);
      else if (cmd.shift_dn) rd_addr = wr_ff + n_rm;
      else if (req_ff.operation == sit_pkg::OP_READ) rd_addr = CB'(req_ff.entry_index);
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_issue) rd_ff <= mem[rd_addr[IB-1:0]];
      if (cmd.wr_new)
         mem[wr_ff[IB-1:0]] <= '{rbegin: req_ff.range_begin, rend: req_ff.range_end,
                                payload: req_ff.payload};
      else if (cmd.mv_wr)
         mem[wr_ff[IB-1:0]] <= rd_ff;
   end

   always_comb begin
      occ_in  = occ_ff;
      if (cmd.cnt_inc) occ_in = occ_ff + CB'(1);
      if (cmd.cnt_dec) occ_in = occ_ff - n_rm;
      scan_in = cmd.load ? '0 : (cmd.scan_step ? scan_ff + CB'(1) : scan_ff);
      end_in  = end_ff;
      if (cmd.load) end_in = '0;
      else if (cmd.mark_end) end_in = scan_ff;
      else if (cmd.mv_wr && cmd.shift_dn) end_in = end_ff + CB'(1);
      wr_in   = wr_ff;
      if (cmd.load) wr_in = '0;
      else if (cmd.set_cursor) wr_in = cmd.shift_up ? occ_ff : scan_ff;
      else if (cmd.mv_wr) wr_in = cmd.shift_up ? wr_ff - CB'(1) : wr_ff + CB'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
      scan_ff <= scan_in;
      end_ff  <= end_in;
      wr_ff   <= wr_in;
      if (cmd.load) req_ff <= req_data;
      if (cmd.load) begin
         fb_ff <= '0; fe_ff <= '0; fp_ff <= '0;
      end else if (cmd.capture) begin
         fb_ff <= 48'(rd_ff.rbegin);
         fe_ff <= 48'(rd_ff.rend);
         fp_ff <= 32'(rd_ff.payload);
      end
      if (cmd.rsp_load) begin
         rsp_ff.status        <= cmd.status;
         rsp_ff.found_begin   <= fb_ff;
         rsp_ff.found_end     <= fe_ff;
         rsp_ff.found_payload <= fp_ff;
         rsp_ff.removed_count <= 7'(n_rm);
         rsp_ff.entry_count   <= 7'(occ_ff);
      end
   end

   always_comb begin
      sts.operation    = req_ff.operation;
      sts.scan_done    = (scan_ff >= occ_ff);
      sts.end_le_key   = (rd_ff.rend <= key);
      sts.begin_le_key = (rd_ff.rbegin <= req_ff.point);
      sts.overlap      = (req_ff.range_begin >= rd_ff.rbegin &&
                          req_ff.range_begin < rd_ff.rend) ||
                         (rd_ff.rbegin >= req_ff.range_begin &&
                          rd_ff.rbegin < req_ff.range_end);
      sts.begin_lt_end = (rd_ff.rbegin < req_ff.range_end);
      sts.full         = (occ_ff >= CB'(sit_pkg::CAPACITY));
      sts.idx_ok       = (CB'(req_ff.entry_index) < occ_ff);
      sts.move_done    = (req_ff.operation == sit_pkg::OP_INSERT) ? (wr_ff == scan_ff) :
                         (wr_ff + n_rm >= occ_ff);
   end

   assign rsp_data = rsp_ff;

`ifndef NO_ASSERTIONS
   a_occ_cap: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CB'(sit_pkg::CAPACITY)) else $error("occupancy above capacity");
   a_inc_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !sts.full) else $error("insert into full table");
   a_rm_cnt: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> end_ff <= occ_ff && wr_ff <= end_ff) else $error("bad removal span");
`endif
endmodule
`default_nettype wire

// ----- sv/sit_ctrl.sv -----
// Controller: sequences scans, shifts and result handoff for each request.
`default_nettype none
module sit_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire sit_pkg::sts_type sts,
   output sit_pkg::cmd_type      cmd
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_SCAN  = 11'b00000000010,
      S_TEST  = 11'b00000000100,
      S_SPAN  = 11'b00000001000,
      S_SPANT = 11'b00000010000,
      S_UP    = 11'b00000100000,
      S_UPW   = 11'b00001000000,
      S_DN    = 11'b00010000000,
      S_DNW   = 11'b00100000000,
      S_CAP   = 11'b01000000000,
      S_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rspv_ff, rspv_in;
   logic [2:0] st_ff, st_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rspv_ff;

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      cmd      = '0;
      cmd.status = st_ff;
      rspv_in  = rspv_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               st_in    = sit_pkg::ST_OK;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.operation == sit_pkg::OP_READ) begin
               if (sts.idx_ok) begin
                  cmd.rd_issue = 1'b1;
                  state_in = S_CAP;
               end else begin
                  st_in = sit_pkg::ST_BAD_INDEX;
                  state_in = S_DONE;
               end
            end else if (sts.operation > sit_pkg::OP_READ) begin
               state_in = S_DONE;
            end else if (sts.scan_done) begin
               cmd.mark_end = 1'b1; cmd.set_cursor = 1'b1;
               if (sts.operation == sit_pkg::OP_INSERT) begin
                  if (sts.full) begin st_in = sit_pkg::ST_FULL; state_in = S_DONE; end
                  else begin
                     cmd.shift_up = 1'b1;
                     state_in = S_UP;
                  end
               end else if (sts.operation == sit_pkg::OP_DEL_RANGE) state_in = S_DONE;
               else begin st_in = sit_pkg::ST_NOT_FOUND; state_in = S_DONE; end
            end else begin
               cmd.rd_issue = 1'b1;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (sts.end_le_key) begin
               cmd.scan_step = 1'b1;
               state_in = S_SCAN;
            end else begin
               cmd.mark_end = 1'b1; cmd.set_cursor = 1'b1;
               unique case (sts.operation)
                  sit_pkg::OP_INSERT: begin
                     if (sts.overlap) begin st_in = sit_pkg::ST_OVERLAP; state_in = S_DONE; end
                     else if (sts.full) begin st_in = sit_pkg::ST_FULL; state_in = S_DONE; end
                     else begin
                        cmd.shift_up = 1'b1;
                        state_in = S_UP;
                     end
                  end
                  sit_pkg::OP_DEL_POINT: begin
                     if (sts.begin_le_key) begin
                        cmd.scan_step = 1'b1; state_in = S_SPAN;
                     end else begin st_in = sit_pkg::ST_NOT_FOUND; state_in = S_DONE; end
                  end
                  sit_pkg::OP_FIND: begin
                     if (sts.begin_le_key) begin cmd.capture = 1'b1; state_in = S_DONE; end
                     else begin st_in = sit_pkg::ST_NOT_FOUND; state_in = S_DONE; end
                  end
                  default: state_in = S_SPANT;
               endcase
            end
         end
         S_SPAN: begin
            // next span entry for range delete, else span end fixed
            if (sts.operation == sit_pkg::OP_DEL_RANGE && !sts.scan_done) begin
               cmd.rd_issue = 1'b1;
               state_in = S_SPANT;
            end else begin
               cmd.mark_end = 1'b1;
               state_in = S_DN;
            end
         end
         S_SPANT: begin
            if (sts.begin_lt_end) begin
               cmd.scan_step = 1'b1;
               state_in = S_SPAN;
            end else begin
               cmd.mark_end = 1'b1;
               state_in = S_DN;
            end
         end
         S_UP: begin
            cmd.shift_up = 1'b1;
            if (sts.move_done) begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in = S_UPW;
            end
         end
         S_UPW: begin
            cmd.shift_up = 1'b1;
            cmd.mv_wr = 1'b1;
            state_in = S_UP;
         end
         S_DN: begin
            cmd.shift_dn = 1'b1;
            if (sts.move_done) begin
               cmd.cnt_dec = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in = S_DNW;
            end
         end
         S_DNW: begin
            cmd.shift_dn = 1'b1;
            cmd.mv_wr = 1'b1;
            state_in = S_DN;
         end
         S_CAP: begin
            cmd.capture = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rspv_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rspv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rspv_ff  <= 1'b0;
         st_ff    <= sit_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         rspv_ff  <= rspv_in;
         st_ff    <= st_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("response dropped");
   a_load: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> state_ff == S_DONE) else $error("response loaded early");
`endif
endmodule
`default_nettype wire

// ----- sv/sorted_interval_table_top.sv -----
// Top level: sorted interval table, controller plus datapath.
// Usage:
//   req channel: one request (insert, delete point, delete range, find, read).
//   rsp channel: exactly one response per request, in order.
//   Valid/stall handshake on both; a request is taken at an edge with
//   req_valid high and req_stall low.
//   One request is in work at a time; req_stall is high from acceptance
//   until its response is loaded into the output register.
//   Sequence: a scan of the sorted table, then for insert or delete a shift
//   of later entries (read, then write) through the entry memory; the
//   controller then returns to idle before taking the next request.
//   A read fetches the entry at its index directly, with no scan.
//   The response register holds a valid response while rsp_stall is high; the next
//   request may be accepted meanwhile and waits for it before finishing.
//   Reset empties the table at once; entry memory is not cleared.
`default_nettype none
module sorted_interval_table_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sit_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sit_pkg::rsp_type      rsp_data
);
   sit_pkg::cmd_type cmd;
   sit_pkg::sts_type sts;

   sit_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   sit_datapath u_dp (
      .clock(clock), .reset(reset),
      .req_data(req_data), .cmd(cmd), .sts(sts), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire
